// File: hdl/hrlp_pkg.sv
package hrlp_pkg;

    // Default line length over which byte offsets wrap.
    localparam int unsigned HRLP_MAX_LINE = 4096;

    // Entries in the queue between the classifier and the parser.
    localparam int unsigned HRLP_Q_DEPTH = 2;

    // Width of the reported byte offsets.
    localparam int unsigned POS_OUT_W = 12;

    // Characters the parser looks for.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;

    // Packed method names, first byte highest.
    localparam logic [31:0] METHOD_GET  = 32'h0047_4554;
    localparam logic [31:0] METHOD_HEAD = 32'h4845_4144;
    localparam logic [31:0] METHOD_POST = 32'h504F_5354;

    typedef enum logic [3:0] {
        CC_OTHER,
        CC_CR,
        CC_LF,
        CC_SPACE,
        CC_SLASH,
        CC_DOT,
        CC_H,
        CC_T,
        CC_P
    } char_class_t;

    // One classified byte as it travels from the front end to the parser.
    typedef struct packed {
        logic [7:0]  char_byte;
        char_class_t char_class;
        logic        is_upper;
        logic        is_digit;
        logic        is_nz_digit;
    } byte_item_t;

    typedef enum logic [3:0] {
        ST_START,
        ST_METHOD,
        ST_SP_URI,
        ST_URI,
        ST_PROTO,
        ST_H,
        ST_HT,
        ST_HTT,
        ST_HTTP,
        ST_MAJ_FIRST,
        ST_MAJ,
        ST_MIN_FIRST,
        ST_MIN,
        ST_SP_END,
        ST_CR
    } parse_state_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_DONE       = 2'd1,
        STAT_BAD_METHOD = 2'd2,
        STAT_BAD_REQ    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        METH_GET     = 2'd0,
        METH_HEAD    = 2'd1,
        METH_POST    = 2'd2,
        METH_UNKNOWN = 2'd3
    } method_t;

endpackage

// File: hdl/hrlp_front.sv
module hrlp_front (
    input  logic                byte_valid,
    input  logic [7:0]          byte_data,
    input  logic                queue_full,
    output logic                byte_stall,
    output logic                push,
    output hrlp_pkg::byte_item_t push_item
);
    import hrlp_pkg::*;

    char_class_t cls;

    // Sort each byte into the few classes the parser distinguishes.
    always_comb
    begin
        unique case (byte_data)
            CH_CR:    cls = CC_CR;
            CH_LF:    cls = CC_LF;
            CH_SPACE: cls = CC_SPACE;
            CH_SLASH: cls = CC_SLASH;
            CH_DOT:   cls = CC_DOT;
            CH_H:     cls = CC_H;
            CH_T:     cls = CC_T;
            CH_P:     cls = CC_P;
            default:  cls = CC_OTHER;
        endcase
    end

    always_comb
    begin
        push_item.char_byte   = byte_data;
        push_item.char_class  = cls;
        push_item.is_upper    = (byte_data >= CH_UPPER_A) && (byte_data <= CH_UPPER_Z);
        push_item.is_digit    = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);
        push_item.is_nz_digit = (byte_data > CH_ZERO) && (byte_data <= CH_NINE);
    end

    assign byte_stall = queue_full;
    assign push       = byte_valid && !queue_full;

endmodule

// File: hdl/hrlp_queue.sv
module hrlp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hrlp_pkg::byte_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output hrlp_pkg::byte_item_t head_item
);
    import hrlp_pkg::*;

    localparam int unsigned PTR_W = (HRLP_Q_DEPTH > 1) ? $clog2(HRLP_Q_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(HRLP_Q_DEPTH + 1);

    byte_item_t       entry_reg [HRLP_Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(HRLP_Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(HRLP_Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(HRLP_Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hdl/hrlp_back.sv
module hrlp_back #(
    parameter int unsigned MAX_LINE = hrlp_pkg::HRLP_MAX_LINE
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  hrlp_pkg::byte_item_t head_item,
    output logic                 pop,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [1:0]           res_status,
    output logic [1:0]           res_method,
    output logic [7:0]           res_major,
    output logic [7:0]           res_minor,
    output logic [11:0]          res_meth_end,
    output logic [11:0]          res_uri_open,
    output logic [11:0]          res_uri_end,
    output logic [11:0]          res_line_end
);
    import hrlp_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_LINE);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);

    parse_state_t     state_reg;
    parse_state_t     state_next;
    logic [31:0]      chars_reg;
    logic [31:0]      chars_next;
    logic [2:0]       len_reg;
    logic [2:0]       len_next;
    logic [7:0]       major_reg;
    logic [7:0]       major_next;
    logic [7:0]       minor_reg;
    logic [7:0]       minor_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] meth_end_reg;
    logic [POS_W-1:0] meth_end_next;
    logic [POS_W-1:0] uri_open_reg;
    logic [POS_W-1:0] uri_open_next;
    logic [POS_W-1:0] uri_end_reg;
    logic [POS_W-1:0] uri_end_next;
    method_t          method_reg;
    method_t          method_next;

    status_t          stat;
    logic [POS_W-1:0] line_end;
    logic             full_clear;
    logic [7:0]       c;
    logic [3:0]       digit;
    logic [11:0]      major_mac;
    logic [11:0]      minor_mac;
    logic [7:0]       major_sat;
    logic [7:0]       minor_sat;
    method_t          method_class;

    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          out_status_reg;
    method_t          out_method_reg;
    logic [7:0]       out_major_reg;
    logic [7:0]       out_minor_reg;
    logic [11:0]      out_meth_end_reg;
    logic [11:0]      out_uri_open_reg;
    logic [11:0]      out_uri_end_reg;
    logic [11:0]      out_line_end_reg;

    // Offsets are reported in twelve bits: zero-extend, then keep the low part.
    function automatic logic [11:0] to_out(input logic [POS_W-1:0] p);
        logic [POS_W+11:0] ext;
        ext = {12'b0, p};
        return ext[11:0];
    endfunction

    assign c     = head_item.char_byte;
    assign digit = c[3:0];

    assign major_mac = ({4'b0, major_reg} * 12'd10) + {8'b0, digit};
    assign minor_mac = ({4'b0, minor_reg} * 12'd10) + {8'b0, digit};
    assign major_sat = (major_mac > 12'd255) ? 8'd255 : major_mac[7:0];
    assign minor_sat = (minor_mac > 12'd255) ? 8'd255 : minor_mac[7:0];

    always_comb
    begin
        if (len_reg == 3'd3 && chars_reg == METHOD_GET)
        begin
            method_class = METH_GET;
        end
        else if (len_reg == 3'd4 && chars_reg == METHOD_HEAD)
        begin
            method_class = METH_HEAD;
        end
        else if (len_reg == 3'd4 && chars_reg == METHOD_POST)
        begin
            method_class = METH_POST;
        end
        else
        begin
            method_class = METH_UNKNOWN;
        end
    end

    // A new byte enters whenever the result register is empty or being taken.
    assign pop = head_valid && (!out_valid_reg || !res_stall);

    always_comb
    begin
        state_next     = state_reg;
        chars_next     = chars_reg;
        len_next       = len_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        meth_end_next  = meth_end_reg;
        uri_open_next  = uri_open_reg;
        uri_end_next   = uri_end_reg;
        method_next    = method_reg;
        stat           = STAT_OK;
        line_end       = '0;
        full_clear     = 1'b0;

        unique case (state_reg)
            ST_START:
            begin
                if (head_item.char_class == CC_CR || head_item.char_class == CC_LF)
                begin
                    state_next = ST_START;
                end
                else if (!head_item.is_upper)
                begin
                    stat = STAT_BAD_METHOD;
                end
                else
                begin
                    chars_next = {chars_reg[23:0], c};
                    len_next   = len_reg + 1'b1;
                    state_next = ST_METHOD;
                end
            end
            ST_METHOD:
            begin
                if (head_item.char_class == CC_SPACE)
                begin
                    meth_end_next = pos_reg;
                    method_next   = method_class;
                    state_next    = ST_SP_URI;
                end
                else if (!head_item.is_upper)
                begin
                    stat = STAT_BAD_METHOD;
                end
                else
                begin
                    if (len_reg < 3'd4)
                    begin
                        chars_next = {chars_reg[23:0], c};
                    end
                    if (len_reg != 3'd7)
                    begin
                        len_next = len_reg + 1'b1;
                    end
                end
            end
            ST_SP_URI:
            begin
                if (head_item.char_class == CC_SLASH)
                begin
                    uri_open_next = pos_reg;
                    state_next    = ST_URI;
                end
                else if (head_item.char_class != CC_SPACE)
                begin
                    stat = STAT_BAD_REQ;
                end
            end
            ST_URI:
            begin
                if (head_item.char_class == CC_SPACE)
                begin
                    uri_end_next = pos_reg;
                    state_next   = ST_PROTO;
                end
            end
            ST_PROTO:
            begin
                if (head_item.char_class == CC_H)
                begin
                    state_next = ST_H;
                end
                else if (head_item.char_class != CC_SPACE)
                begin
                    stat = STAT_BAD_REQ;
                end
            end
            ST_H:
            begin
                if (head_item.char_class == CC_T) state_next = ST_HT;
                else stat = STAT_BAD_REQ;
            end
            ST_HT:
            begin
                if (head_item.char_class == CC_T) state_next = ST_HTT;
                else stat = STAT_BAD_REQ;
            end
            ST_HTT:
            begin
                if (head_item.char_class == CC_P) state_next = ST_HTTP;
                else stat = STAT_BAD_REQ;
            end
            ST_HTTP:
            begin
                if (head_item.char_class == CC_SLASH) state_next = ST_MAJ_FIRST;
                else stat = STAT_BAD_REQ;
            end
            ST_MAJ_FIRST:
            begin
                if (head_item.is_nz_digit)
                begin
                    major_next = {4'b0, digit};
                    state_next = ST_MAJ;
                end
                else
                begin
                    stat = STAT_BAD_REQ;
                end
            end
            ST_MAJ:
            begin
                if (head_item.char_class == CC_DOT)
                begin
                    state_next = ST_MIN_FIRST;
                end
                else if (head_item.is_digit)
                begin
                    major_next = major_sat;
                end
                else
                begin
                    stat = STAT_BAD_REQ;
                end
            end
            ST_MIN_FIRST:
            begin
                if (head_item.is_digit)
                begin
                    minor_next = {4'b0, digit};
                    state_next = ST_MIN;
                end
                else
                begin
                    stat = STAT_BAD_REQ;
                end
            end
            ST_MIN, ST_SP_END:
            begin
                if (head_item.char_class == CC_CR)
                begin
                    state_next = ST_CR;
                end
                else if (head_item.char_class == CC_LF)
                begin
                    stat     = STAT_DONE;
                    line_end = pos_reg;
                end
                else if (head_item.char_class == CC_SPACE)
                begin
                    state_next = ST_SP_END;
                end
                else if (state_reg == ST_MIN && head_item.is_digit)
                begin
                    minor_next = minor_sat;
                end
                else
                begin
                    stat = STAT_BAD_REQ;
                end
            end
            ST_CR:
            begin
                if (head_item.char_class == CC_LF)
                begin
                    stat     = STAT_DONE;
                    line_end = (pos_reg == '0) ? POS_LAST : pos_reg - 1'b1;
                end
                else
                begin
                    stat = STAT_BAD_REQ;
                end
            end
            default:
            begin
                // An unused state code clears everything and reports continue.
                full_clear = 1'b1;
            end
        endcase

        if (full_clear || stat != STAT_OK)
        begin
            state_next     = ST_START;
            chars_next     = '0;
            len_next       = '0;
            major_next     = '0;
            minor_next     = '0;
            pos_next       = '0;
            meth_end_next  = '0;
            uri_open_next  = '0;
            uri_end_next   = '0;
            method_next    = METH_UNKNOWN;
        end
        else
        begin
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && res_stall;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            chars_reg     <= '0;
            len_reg       <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            pos_reg       <= '0;
            meth_end_reg  <= '0;
            uri_open_reg  <= '0;
            uri_end_reg   <= '0;
            method_reg    <= METH_UNKNOWN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                state_reg     <= state_next;
                chars_reg     <= chars_next;
                len_reg       <= len_next;
                major_reg     <= major_next;
                minor_reg     <= minor_next;
                pos_reg       <= pos_next;
                meth_end_reg  <= meth_end_next;
                uri_open_reg  <= uri_open_next;
                uri_end_reg   <= uri_end_next;
                method_reg    <= method_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; fields other than status read zero unless the line completed.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_status_reg <= stat;
            if (stat == STAT_DONE)
            begin
                out_method_reg    <= method_reg;
                out_major_reg     <= major_reg;
                out_minor_reg     <= minor_reg;
                out_meth_end_reg  <= to_out(meth_end_reg);
                out_uri_open_reg  <= to_out(uri_open_reg);
                out_uri_end_reg   <= to_out(uri_end_reg);
                out_line_end_reg  <= to_out(line_end);
            end
            else
            begin
                out_method_reg    <= METH_GET;
                out_major_reg     <= '0;
                out_minor_reg     <= '0;
                out_meth_end_reg  <= '0;
                out_uri_open_reg  <= '0;
                out_uri_end_reg   <= '0;
                out_line_end_reg  <= '0;
            end
        end
    end

    assign res_valid      = out_valid_reg;
    assign res_status     = out_status_reg;
    assign res_method     = out_method_reg;
    assign res_major      = out_major_reg;
    assign res_minor      = out_minor_reg;
    assign res_meth_end   = out_meth_end_reg;
    assign res_uri_open   = out_uri_open_reg;
    assign res_uri_end    = out_uri_end_reg;
    assign res_line_end   = out_line_end_reg;

endmodule

// File: hdl/http_request_line_parser_core.sv
// Throughput: one byte per clock cycle while the result side does not stall.
// Path: an accepted byte is written into the queue; the parser pops it when its result
// register is free or being emptied, and the result is held there until it is taken.
// Reset: rst_n clears the queue, the parser state (start state, method unknown, all
// offsets and accumulators zero) and the result valid flag at once.
module http_request_line_parser_core #(
    parameter int unsigned MAX_LINE = hrlp_pkg::HRLP_MAX_LINE
) (
    input  logic        clk,
    input  logic        rst_n,
    // Byte channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    // Result channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [1:0]  method_code,
    output logic [7:0]  version_major,
    output logic [7:0]  version_minor,
    output logic [11:0] method_end_pos,
    output logic [11:0] uri_start_pos,
    output logic [11:0] uri_end_pos,
    output logic [11:0] line_end_pos
);
    import hrlp_pkg::*;

    // The front end classifies every byte as it arrives and drops it into a
    // short queue. The back end pops one classified byte per cycle whenever
    // its result register is free or being emptied, so a stalled result side
    // only backs up the queue, and the input stalls once the queue is full.
    logic       push;
    logic       pop;
    logic       queue_full;
    logic       head_valid;
    byte_item_t push_item;
    byte_item_t head_item;

    hrlp_front u_front (
        .byte_valid (in_valid),
        .byte_data  (byte_in),
        .queue_full (queue_full),
        .byte_stall (in_stall),
        .push       (push),
        .push_item  (push_item)
    );

    hrlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // The parser walks the request line one byte per transfer and produces
    // exactly one result for each byte, with the line fields filled in only
    // when the line completes.
    hrlp_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .pop            (pop),
        .res_valid      (out_valid),
        .res_stall      (out_stall),
        .res_status     (status),
        .res_method     (method_code),
        .res_major      (version_major),
        .res_minor      (version_minor),
        .res_meth_end   (method_end_pos),
        .res_uri_open   (uri_start_pos),
        .res_uri_end    (uri_end_pos),
        .res_line_end   (line_end_pos)
    );

endmodule
